// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the lookup unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define ASSERT_IMPLIES(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// The property must hold in the cycle after the condition.
`define ASSERT_NEXT(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// File: rtl/bwd_pkg.sv
// ----------------------------------------------------------------------------
// Bucketed word dictionary package
// Command types, queue constants and character helpers.
// ----------------------------------------------------------------------------
package bwd_pkg;

   localparam int LETTERS   = 26;
   localparam int TALLY_W   = 13;
   localparam logic [TALLY_W-1:0] TALLY_MAX = 13'd8191;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = 2;
   localparam int QCNT_W    = 3;

   typedef enum logic [1:0] {
      OP_TALLY = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  code;
      logic        last;
      logic        letter_ok;
      logic [4:0]  letter;
   } cmd_type;

   typedef struct packed {
      logic              valid;
      logic [QCNT_W-1:0] count;
   } qstat_type;

   typedef struct packed {
      logic in_query;
   } estat_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
   endfunction

   function automatic logic [4:0] letter_of(input logic [7:0] c);
      logic [7:0] d;
      d = (c > 8'd96) ? (c - 8'd97) : (c - 8'd65);
      return d[4:0];
   endfunction

endpackage

// File: rtl/bucketed_word_dictionary_lookup_unit.sv
// ----------------------------------------------------------------------------
// Bucketed word dictionary lookup unit
// Builds a first-letter bucketed dictionary and answers exact-match queries.
// ----------------------------------------------------------------------------
//  Channel   Ports                                     Handshake
//  request   req_type, req_char_code, req_last_char    start high, busy low
//  response  rsp_is_typo                               rsp_valid, one cycle
//
// A tally beat is handled in the idle state; a load beat passes through the load
// states, and the first load beat also runs a prefix sum over the letter counts.
// A query end passes a start state, then per stored word in its bucket a check
// state and a read and a compare state per byte on the word store's single read
// port, and one more check when no word matches; the verdict is then registered.
// Reset clears all counts, bucket offsets and the queue; the store is not cleared.
// Busy rises only when the four-entry command queue is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bucketed_word_dictionary_lookup_unit import bwd_pkg::*; #(
   parameter int WORD_SLOTS = 4096,
   parameter int SLOT_BYTES = 29
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_type,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   output logic       rsp_valid,
   output logic       rsp_is_typo
);

   cmd_type   f_cmd, q_cmd;
   qstat_type q_stat;
   estat_type e_stat;
   logic      push, pop, q_full;

   bwd_front u_front (
      .start         (start),
      .req_type      (req_type),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .q_full        (q_full),
      .busy          (busy),
      .push          (push),
      .cmd           (f_cmd)
   );

   bwd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .cmd_in  (f_cmd),
      .pop     (pop),
      .cmd_out (q_cmd),
      .stat    (q_stat),
      .full    (q_full)
   );

   bwd_engine #(
      .WORD_SLOTS (WORD_SLOTS),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_stat.valid),
      .q_cmd       (q_cmd),
      .pop         (pop),
      .stat        (e_stat),
      .rsp_valid   (rsp_valid),
      .rsp_is_typo (rsp_is_typo)
   );

   `ASSERT_NEXT(a_queue_grows, clock, reset, push && !pop, q_stat.count == $past(q_stat.count) + 1'b1)
   `ASSERT_IMPLIES(a_rsp_from_query, clock, reset, rsp_valid, $past(e_stat.in_query))
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)

endmodule

// File: rtl/bwd_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts request beats and classifies them into queue commands.
// ----------------------------------------------------------------------------
module bwd_front import bwd_pkg::*; (
   input  logic       start,
   input  logic [1:0] req_type,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   input  logic       q_full,
   output logic       busy,
   output logic       push,
   output cmd_type    cmd
);

   logic known;

   always_comb begin
      known = 1'b1;
      cmd.op = OP_TALLY;
      unique case (req_type)
         OP_TALLY: cmd.op = OP_TALLY;
         OP_LOAD:  cmd.op = OP_LOAD;
         OP_QUERY: cmd.op = OP_QUERY;
         default: known = 1'b0;
      endcase
      cmd.code      = req_char_code;
      cmd.last      = req_last_char;
      cmd.letter_ok = is_letter(req_char_code);
      cmd.letter    = letter_of(req_char_code);
   end

   assign busy = q_full;
   assign push = start && !q_full && known;

endmodule

// File: rtl/bwd_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO that decouples the front end from the engine.
// ----------------------------------------------------------------------------
module bwd_queue import bwd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   cmd_in,
   input  logic      pop,
   output cmd_type   cmd_out,
   output qstat_type stat,
   output logic      full
);

   cmd_type           q_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_pop;

   assign full       = (cnt_ff == QCNT_W'(QDEPTH));
   assign stat.valid = (cnt_ff != '0);
   assign stat.count = cnt_ff;
   assign cmd_out    = q_ff[rd_ff];
   assign do_pop     = pop && stat.valid;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= cmd_in;
      end
   end

endmodule

// File: rtl/bwd_engine.sv
// ----------------------------------------------------------------------------
// Dictionary engine
// Executes tally, load and query commands against the word store.
// ----------------------------------------------------------------------------
module bwd_engine import bwd_pkg::*; #(
   parameter int WORD_SLOTS = 4096,
   parameter int SLOT_BYTES = 29
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  cmd_type   q_cmd,
   output logic      pop,
   output estat_type stat,
   output logic      rsp_valid,
   output logic      rsp_is_typo
);

   localparam int DEPTH = WORD_SLOTS * SLOT_BYTES;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = $clog2(WORD_SLOTS);
   localparam int SW1   = $clog2(WORD_SLOTS + 1);
   localparam int PW    = $clog2(SLOT_BYTES);
   localparam int QN    = SLOT_BYTES - 1;
   localparam int QIW   = (QN > 1) ? $clog2(QN) : 1;
   localparam int SUMW  = ((SW1 > TALLY_W) ? SW1 : TALLY_W) + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_BUILD, S_LOAD, S_LOAD_BASE, S_LOAD_WR, S_LOAD_TERM,
      S_QSTART, S_SCAN_CHECK, S_SCAN_RD, S_SCAN_CMP
   } state_type;

   logic [7:0]         mem [DEPTH];
   logic [7:0]         mem_q_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_wa, mem_ra;
   logic [7:0]         mem_wd;

   state_type          state_ff, state_in;
   cmd_type            cur_ff, cur_in;
   logic [TALLY_W-1:0] tally_ff [LETTERS];
   logic [TALLY_W-1:0] tally_in [LETTERS];
   logic [SW1-1:0]     start_ff [LETTERS];
   logic [SW1-1:0]     start_in [LETTERS];
   logic [SW1-1:0]     end_ff   [LETTERS];
   logic [SW1-1:0]     end_in   [LETTERS];
   logic [SW1-1:0]     fill_ff  [LETTERS];
   logic [SW1-1:0]     fill_in  [LETTERS];
   logic               ready_ff, ready_in;
   logic [4:0]         bidx_ff, bidx_in;
   logic               in_word_ff, in_word_in;
   logic               keep_ff, keep_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [4:0]         lletter_ff, lletter_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [AW-1:0]      lbase_ff, lbase_in;
   logic [7:0]         qchar_ff [QN];
   logic               qchar_we;
   logic [QIW-1:0]     qchar_wa;
   logic [PW-1:0]      qlen_ff, qlen_in;
   logic               qover_ff, qover_in;
   logic [4:0]         sletter_ff, sletter_in;
   logic [SW1-1:0]     sidx_ff, sidx_in;
   logic [AW-1:0]      sbase_ff, sbase_in;
   logic [PW-1:0]      k_ff, k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_typo_ff, rsp_typo_in;

   always_comb begin
      logic [SUMW-1:0] sum;
      logic [SW1:0]    slot_sum;
      logic            fin, fin_v, next_slot;
      state_in     = state_ff;
      cur_in       = cur_ff;
      tally_in     = tally_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      fill_in      = fill_ff;
      ready_in     = ready_ff;
      bidx_in      = bidx_ff;
      in_word_in   = in_word_ff;
      keep_in      = keep_ff;
      pos_in       = pos_ff;
      lletter_in   = lletter_ff;
      slot_in      = slot_ff;
      lbase_in     = lbase_ff;
      qlen_in      = qlen_ff;
      qover_in     = qover_ff;
      sletter_in   = sletter_ff;
      sidx_in      = sidx_ff;
      sbase_in     = sbase_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_typo_in  = rsp_typo_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = lbase_ff + AW'(pos_ff);
      mem_wd       = '0;
      mem_ra       = sbase_ff + AW'(k_ff);
      qchar_we     = 1'b0;
      qchar_wa     = qlen_ff[QIW-1:0];
      fin          = 1'b0;
      fin_v        = 1'b1;
      next_slot    = 1'b0;
      sum          = SUMW'(start_ff[bidx_ff]) + SUMW'(tally_ff[bidx_ff]);
      slot_sum     = (SW1+1)'(start_ff[cur_ff.letter]) + (SW1+1)'(fill_ff[cur_ff.letter]);

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               pop    = 1'b1;
               cur_in = q_cmd;
               case (q_cmd.op)
                  OP_TALLY: begin
                     if (!ready_ff && q_cmd.letter_ok &&
                         tally_ff[q_cmd.letter] != TALLY_MAX) begin
                        tally_in[q_cmd.letter] = tally_ff[q_cmd.letter] + 1'b1;
                     end
                  end
                  OP_LOAD: begin
                     bidx_in  = '0;
                     state_in = ready_ff ? S_LOAD : S_BUILD;
                  end
                  OP_QUERY: begin
                     if (qlen_ff < PW'(QN)) begin
                        qchar_we = 1'b1;
                        qlen_in  = qlen_ff + 1'b1;
                     end else begin
                        qover_in = 1'b1;
                     end
                     if (q_cmd.last) begin
                        state_in = S_QSTART;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_BUILD: begin
            if (sum > SUMW'(WORD_SLOTS)) begin
               sum = SUMW'(WORD_SLOTS);
            end
            end_in[bidx_ff]  = sum[SW1-1:0];
            fill_in[bidx_ff] = '0;
            if (bidx_ff == 5'(LETTERS - 1)) begin
               ready_in = 1'b1;
               state_in = S_LOAD;
            end else begin
               start_in[bidx_ff + 5'd1] = sum[SW1-1:0];
               bidx_in = bidx_ff + 5'd1;
            end
         end
         S_LOAD: begin
            if (!in_word_ff) begin
               in_word_in = 1'b1;
               keep_in    = 1'b0;
               pos_in     = '0;
               if (cur_ff.letter_ok && slot_sum < (SW1+1)'(end_ff[cur_ff.letter])) begin
                  keep_in    = 1'b1;
                  slot_in    = slot_sum[SW-1:0];
                  lletter_in = cur_ff.letter;
                  state_in   = S_LOAD_BASE;
               end else begin
                  if (cur_ff.last) begin
                     in_word_in = 1'b0;
                  end
                  state_in = S_IDLE;
               end
            end else if (keep_ff) begin
               state_in = S_LOAD_WR;
            end else begin
               if (cur_ff.last) begin
                  in_word_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         S_LOAD_BASE: begin
            lbase_in = AW'(slot_ff) * AW'(SLOT_BYTES);
            state_in = S_LOAD_WR;
         end
         S_LOAD_WR: begin
            if (pos_ff < PW'(QN)) begin
               mem_we = 1'b1;
               mem_wd = cur_ff.code;
               pos_in = pos_ff + 1'b1;
            end
            state_in = cur_ff.last ? S_LOAD_TERM : S_IDLE;
         end
         S_LOAD_TERM: begin
            mem_we              = 1'b1;
            fill_in[lletter_ff] = fill_ff[lletter_ff] + 1'b1;
            in_word_in          = 1'b0;
            keep_in             = 1'b0;
            pos_in              = '0;
            state_in            = S_IDLE;
         end
         S_QSTART: begin
            if (qover_ff || qlen_ff == '0 || !is_letter(qchar_ff[0])) begin
               fin = 1'b1;
            end else begin
               sletter_in = letter_of(qchar_ff[0]);
               sidx_in    = '0;
               sbase_in   = AW'(start_ff[letter_of(qchar_ff[0])]) * AW'(SLOT_BYTES);
               state_in   = S_SCAN_CHECK;
            end
         end
         S_SCAN_CHECK: begin
            if (sidx_ff == fill_ff[sletter_ff]) begin
               fin = 1'b1;
            end else begin
               k_in     = '0;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (k_ff == qlen_ff) begin
               if (mem_q_ff == 8'd0) begin
                  fin   = 1'b1;
                  fin_v = 1'b0;
               end else begin
                  next_slot = 1'b1;
               end
            end else if (mem_q_ff == 8'd0 || mem_q_ff != qchar_ff[k_ff[QIW-1:0]]) begin
               next_slot = 1'b1;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (next_slot) begin
         sidx_in  = sidx_ff + 1'b1;
         sbase_in = sbase_ff + AW'(SLOT_BYTES);
         state_in = S_SCAN_CHECK;
      end
      if (fin) begin
         rsp_valid_in = 1'b1;
         rsp_typo_in  = fin_v;
         qlen_in      = '0;
         qover_in     = 1'b0;
         state_in     = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b0;
         in_word_ff   <= 1'b0;
         keep_ff      <= 1'b0;
         pos_ff       <= '0;
         qlen_ff      <= '0;
         qover_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LETTERS; i++) begin
            tally_ff[i] <= '0;
            start_ff[i] <= '0;
            end_ff[i]   <= '0;
            fill_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         in_word_ff   <= in_word_in;
         keep_ff      <= keep_in;
         pos_ff       <= pos_in;
         qlen_ff      <= qlen_in;
         qover_ff     <= qover_in;
         rsp_valid_ff <= rsp_valid_in;
         tally_ff     <= tally_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         fill_ff      <= fill_in;
      end
      cur_ff      <= cur_in;
      bidx_ff     <= bidx_in;
      lletter_ff  <= lletter_in;
      slot_ff     <= slot_in;
      lbase_ff    <= lbase_in;
      sletter_ff  <= sletter_in;
      sidx_ff     <= sidx_in;
      sbase_ff    <= sbase_in;
      k_ff        <= k_in;
      rsp_typo_ff <= rsp_typo_in;
      if (qchar_we) begin
         qchar_ff[qchar_wa] <= q_cmd.code;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[mem_ra];
   end

   assign stat.in_query = (state_ff == S_QSTART) || (state_ff == S_SCAN_CHECK) ||
                          (state_ff == S_SCAN_RD) || (state_ff == S_SCAN_CMP);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_is_typo = rsp_typo_ff;

endmodule

// File: bench/tb_bucketed_word_dictionary_lookup_unit.sv
// ----------------------------------------------------------------------------
// Lookup unit testbench
// Builds one dictionary through the tally and load passes, then checks the
// typo verdict of directed and random queries against a behavioral predictor
// of the bucketed store, with random start gaps and a busy-driven handshake.
// ----------------------------------------------------------------------------
module tb_bucketed_word_dictionary_lookup_unit import bwd_pkg::*;;

   localparam int SLOTS     = 4096;
   localparam int BYTES     = 29;
   localparam int MAXQ      = BYTES - 1;
   localparam int WMAX      = 40;
   localparam int LIMIT     = 10000000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [7:0] ch [0:WMAX-1];
      int         len;
   } word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_type = OP_TALLY;
   logic [7:0] req_char_code = 8'd0;
   logic       req_last_char = 1'b0;
   logic       rsp_valid;
   logic       rsp_is_typo;

   // Predicted dictionary state.
   logic [7:0] store_bytes [0:SLOTS*BYTES-1];
   int         tally [0:LETTERS-1];
   int         bstart [0:LETTERS];
   int         filled [0:LETTERS-1];
   bit         starts_built, loading, keeping;
   int         cur_slot, cur_pos;
   logic [7:0] qword [0:MAXQ-1];
   int         qlen;
   bit         qlong;

   bit        verdicts [$];
   word_type  dict [$];
   int        errors = 0;
   int        beats = 0;
   int        cycles = 0;
   bit        no_gaps = 1'b0;

   bucketed_word_dictionary_lookup_unit #(.WORD_SLOTS(SLOTS), .SLOT_BYTES(BYTES)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_char_code(req_char_code), .req_last_char(req_last_char),
      .rsp_valid(rsp_valid), .rsp_is_typo(rsp_is_typo)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic bit letter(logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
   endfunction

   function automatic int bucket(logic [7:0] c);
      return c > 8'd96 ? int'(c) - 97 : int'(c) - 65;
   endfunction

   task automatic report(string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (verdicts.size() == 0)
            report("verdict with none expected");
         else if (rsp_is_typo !== verdicts[0]) begin
            report($sformatf("is_typo %b, expected %b", rsp_is_typo, verdicts[0]));
            void'(verdicts.pop_front());
         end else
            void'(verdicts.pop_front());
      end
   end

   function automatic bit slot_hit(int s);
      int base;
      base = s * BYTES;
      for (int k = 0; k < qlen; k++)
         if (store_bytes[base+k] == 8'd0 || store_bytes[base+k] != qword[k])
            return 1'b0;
      return store_bytes[base+qlen] == 8'd0;
   endfunction

   function automatic bit typo_verdict();
      int l;
      if (qlong || qlen == 0 || !letter(qword[0]))
         return 1'b1;
      l = bucket(qword[0]);
      for (int i = 0; i < filled[l]; i++)
         if (slot_hit(bstart[l] + i))
            return 1'b0;
      return 1'b1;
   endfunction

   task automatic predict_load(logic [7:0] c, bit last);
      int l, base;
      if (!starts_built) begin
         bstart[0] = 0;
         for (int i = 0; i < LETTERS; i++) begin
            bstart[i+1] = bstart[i] + tally[i] > SLOTS ? SLOTS : bstart[i] + tally[i];
            filled[i] = 0;
         end
         starts_built = 1'b1;
      end
      if (!loading) begin
         loading = 1'b1;
         keeping = 1'b0;
         cur_pos = 0;
         if (letter(c)) begin
            l = bucket(c);
            if (filled[l] < bstart[l+1] - bstart[l]) begin
               keeping = 1'b1;
               cur_slot = bstart[l] + filled[l];
            end
         end
      end
      if (keeping) begin
         base = cur_slot * BYTES;
         if (cur_pos < MAXQ) begin
            store_bytes[base+cur_pos] = c;
            cur_pos++;
         end
         if (last) begin
            store_bytes[base+cur_pos] = 8'd0;
            filled[bucket(store_bytes[base])]++;
         end
      end
      if (last) begin
         loading = 1'b0;
         keeping = 1'b0;
         cur_pos = 0;
      end
   endtask

   task automatic predict(logic [1:0] op, logic [7:0] c, bit last);
      case (op)
         OP_TALLY: begin
            if (!starts_built && letter(c) && tally[bucket(c)] < int'(TALLY_MAX))
               tally[bucket(c)]++;
         end
         OP_LOAD: predict_load(c, last);
         OP_QUERY: begin
            if (qlen < MAXQ) begin
               qword[qlen] = c;
               qlen++;
            end else
               qlong = 1'b1;
            if (last) begin
               verdicts.push_back(typo_verdict());
               qlen = 0;
               qlong = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic send(logic [1:0] op, logic [7:0] c, bit last);
      if (!no_gaps && $urandom_range(99) < 35) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= op;
      req_char_code <= c;
      req_last_char <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict(op, c, last);
      beats++;
   endtask

   task automatic send_word(logic [1:0] op, word_type w);
      for (int i = 0; i < w.len; i++)
         send(op, w.ch[i], i == w.len - 1);
   endtask

   function automatic word_type make_word(int len, logic [7:0] first);
      word_type w;
      w.len = len;
      for (int i = 0; i < WMAX; i++)
         w.ch[i] = $urandom_range(1) ? 8'($urandom_range(90, 65)) : 8'($urandom_range(122, 97));
      w.ch[0] = first;
      return w;
   endfunction

   function automatic logic [7:0] rand_first();
      logic [7:0] c;
      c = 8'($urandom_range(23));
      return $urandom_range(1) ? c + 8'd65 : c + 8'd97;
   endfunction

   task automatic test_query_empty();
      send_word(OP_QUERY, make_word(4, "m"));
      send_word(OP_QUERY, make_word(1, "A"));
   endtask

   task automatic test_tally();
      word_type w;
      logic [7:0] odd [0:5] = '{8'd0, 8'd64, 8'd91, 8'd96, 8'd123, 8'd255};
      for (int i = 0; i < 60; i++) begin
         w = make_word($urandom_range(12, 1), rand_first());
         if (i % 25 == 0)
            w.len = $urandom_range(34, 29);
         dict.push_back(w);
         send(OP_TALLY, $urandom_range(1) ? w.ch[0] : w.ch[0] ^ 8'h20, 1'b0);
      end
      w = make_word(5, "b");
      w.ch[2] = 8'd0;
      dict.push_back(w);
      send(OP_TALLY, "B", 1'b1);
      foreach (odd[i])
         send(OP_TALLY, odd[i], 1'b0);
      send(OP_UNUSED, "a", 1'b1);
      for (int i = 0; i < 8; i++)
         send(OP_TALLY, i % 2 ? "y" : "Y", 1'b0);
   endtask

   task automatic test_load();
      word_type w;
      w = dict[0];
      for (int i = 0; i < w.len - 1; i++)
         send(OP_LOAD, w.ch[i], 1'b0);
      send_word(OP_QUERY, w);
      send(OP_LOAD, w.ch[w.len-1], 1'b1);
      for (int i = 1; i < dict.size(); i++)
         send_word(OP_LOAD, dict[i]);
      send_word(OP_LOAD, make_word(6, "5"));
      send_word(OP_LOAD, make_word(3, 8'd0));
      for (int i = 0; i < 6; i++) begin
         w = make_word($urandom_range(6, 2), "x");
         dict.push_back(w);
         send_word(OP_LOAD, w);
      end
      w = make_word(4, "z");
      dict.push_back(w);
      send_word(OP_LOAD, w);
      send(OP_UNUSED, "z", 1'b1);
   endtask

   task automatic test_frozen_tally();
      for (int i = 0; i < 5; i++)
         send(OP_TALLY, "c", 1'b0);
   endtask

   task automatic test_query_directed();
      word_type w;
      foreach (dict[i])
         if (i < 8 || dict[i].len > MAXQ) begin
            send_word(OP_QUERY, dict[i]);
            w = dict[i];
            if (w.len > MAXQ) begin
               w.len = MAXQ;
               send_word(OP_QUERY, w);
            end
         end
      w = dict[1];
      w.ch[0] ^= 8'h20;
      send_word(OP_QUERY, w);
      send_word(OP_QUERY, make_word(3, "@"));
      w = dict[$];
      send_word(OP_QUERY, w);
      w = make_word(5, "b");
      w.ch[2] = 8'd0;
      send_word(OP_QUERY, w);
   endtask

   task automatic test_random();
      word_type w;
      int r, k;
      while (beats < 1650) begin
         no_gaps = beats > 1100 && beats < 1400;
         r = $urandom_range(99);
         if (r < 50) begin
            send_word(OP_QUERY, dict[$urandom_range(dict.size() - 1)]);
         end else if (r < 68) begin
            w = dict[$urandom_range(dict.size() - 1)];
            k = $urandom_range(w.len - 1);
            case ($urandom_range(3))
               0: w.ch[k] ^= 8'h20;
               1: w.ch[k] = 8'($urandom_range(255));
               2: w.len = w.len > 1 ? w.len - 1 : 1;
               default: w.len = w.len < WMAX ? w.len + 1 : w.len;
            endcase
            send_word(OP_QUERY, w);
         end else if (r < 80 && dict.size() < 300) begin
            w = make_word($urandom_range(10, 1), rand_first());
            dict.push_back(w);
            send_word(OP_LOAD, w);
         end else if (r < 90) begin
            w.len = $urandom_range(32, 1);
            for (int i = 0; i < WMAX; i++)
               w.ch[i] = 8'($urandom_range(255));
            send_word(OP_QUERY, w);
         end else begin
            send($urandom_range(1) ? OP_UNUSED : OP_TALLY, 8'($urandom_range(255)),
                 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      foreach (tally[i]) begin
         tally[i] = 0;
         filled[i] = 0;
      end
      foreach (bstart[i])
         bstart[i] = 0;
      starts_built = 1'b0;
      loading = 1'b0;
      keeping = 1'b0;
      cur_slot = 0;
      cur_pos = 0;
      qlen = 0;
      qlong = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_query_empty();
      test_tally();
      test_load();
      test_frozen_tally();
      test_query_directed();
      test_random();
      start <= 1'b0;
      while (verdicts.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && verdicts.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
